// ===== src/e2q_pkg.sv =====
// ============================================================================
// Euler-to-quaternion package
// Shared constants, CORDIC arctangent table and the stage data type.
// ============================================================================
package e2q_pkg;

    localparam int ANG_W        = 18;
    localparam int OUT_W        = 18;
    localparam int CW           = 34;   // CORDIC datapath width, Q.30 plus guard bits
    localparam int SC_W         = 22;   // sine/cosine width, Q.20
    localparam int TABLE_LEN    = 24;
    localparam int DEF_STEPS    = 16;

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [36:0]   TWO_PI_Q30  = 37'sd6746518852;
    localparam logic signed [36:0]   PI_Q30_W    = 37'sd3373259426;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } rot_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] r;
        begin
            case (idx)
                0:  r = 34'sd843314856;
                1:  r = 34'sd497837829;
                2:  r = 34'sd263043836;
                3:  r = 34'sd133525158;
                4:  r = 34'sd67021686;
                5:  r = 34'sd33543515;
                6:  r = 34'sd16775850;
                7:  r = 34'sd8388437;
                8:  r = 34'sd4194282;
                9:  r = 34'sd2097149;
                10: r = 34'sd1048575;
                11: r = 34'sd524287;
                12: r = 34'sd262143;
                13: r = 34'sd131071;
                14: r = 34'sd65535;
                15: r = 34'sd32767;
                16: r = 34'sd16383;
                17: r = 34'sd8191;
                18: r = 34'sd4095;
                19: r = 34'sd2047;
                20: r = 34'sd1023;
                21: r = 34'sd511;
                22: r = 34'sd255;
                23: r = 34'sd127;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/euler_angles_to_quaternion.sv =====
// Pipeline: the input reduce register, STEPS CORDIC cells, then sin/cos, pair product,
// triple product and output registers (STEPS = min(CORDIC_STEPS, 24)).
// Throughput: one angle triple per cycle; the chain of CORDIC cells and the
// product stages advance together whenever the output register is free.
// Reset: rst_n asynchronously clears all valid bits; payload registers are not reset.
// ============================================================================
// Euler angles to quaternion
// Converts pitch/yaw/roll in Q4.13 to a unit quaternion in Q1.16.
// ============================================================================
module euler_angles_to_quaternion #(
    parameter int CORDIC_STEPS = e2q_pkg::DEF_STEPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [e2q_pkg::ANG_W-1:0]    pitch_angle,
    input  logic signed [e2q_pkg::ANG_W-1:0]    yaw_angle,
    input  logic signed [e2q_pkg::ANG_W-1:0]    roll_angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [e2q_pkg::OUT_W-1:0]    quat_x,
    output logic signed [e2q_pkg::OUT_W-1:0]    quat_y,
    output logic signed [e2q_pkg::OUT_W-1:0]    quat_z,
    output logic signed [e2q_pkg::OUT_W-1:0]    quat_w
);
    import e2q_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    // Stages: input reduce, STEPS cells, sin/cos round, pair products,
    // split triple products, output.
    localparam int NST = STEPS + 5;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic           adv;

    rot_t chain [STEPS+1][3];
    rot_t red_next [3];

    // The whole pipeline moves together; it holds only when the output is stalled
    // with a result waiting.
    assign adv      = !(vld_reg[NST-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[NST-1];

    always_comb
    begin
        vld_next = {vld_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Range reduction: half angle in Q.30, wrapped into [-pi, pi] then folded
    // into [-pi/2, pi/2] with a sign flag. A Q4.13 input halved stays under
    // 3 pi in magnitude, so a single wrap step suffices.
    always_comb
    begin
        logic signed [ANG_W-1:0] ang [3];
        logic signed [36:0] a;
        ang[0] = pitch_angle;
        ang[1] = yaw_angle;
        ang[2] = roll_angle;
        for (int k = 0; k < 3; k++)
        begin
            a = 37'(ang[k]) <<< 16;
            if (a > PI_Q30_W)
                a = a - TWO_PI_Q30;
            else if (a < -PI_Q30_W)
                a = a + TWO_PI_Q30;
            red_next[k].neg = 1'b0;
            if (a > 37'(HALF_PI_Q30))
            begin
                a = a - PI_Q30_W;
                red_next[k].neg = 1'b1;
            end
            else if (a < -37'(HALF_PI_Q30))
            begin
                a = a + PI_Q30_W;
                red_next[k].neg = 1'b1;
            end
            red_next[k].z = a[CW-1:0];
            red_next[k].x = GAIN_Q30;
            red_next[k].y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chain[0] <= red_next;
        end
    end

    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        e2q_cell #(.STEP(g)) u_cell (
            .clk  (clk),
            .en   (adv),
            .rin  (chain[g]),
            .rout (chain[g+1])
        );
    end

    e2q_combine u_comb (
        .clk (clk),
        .en1 (adv),
        .en2 (adv),
        .en3 (adv),
        .en4 (adv),
        .rin (chain[STEPS]),
        .qx  (quat_x),
        .qy  (quat_y),
        .qz  (quat_z),
        .qw  (quat_w)
    );

`ifndef SYNTHESIS
    // A stalled result must stay valid.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    // Input is refused only while a result is held back.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
    // quat_w stays within plus or minus one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= 18'sd65536 && quat_w >= -18'sd65536)
        else $error("quat_w out of range");
`endif

endmodule

// ===== src/e2q_cell.sv =====
// ============================================================================
// CORDIC cell
// One rotation step for the three angle lanes, registered when enabled.
// ============================================================================
module e2q_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           en,
    input  e2q_pkg::rot_t  rin  [3],
    output e2q_pkg::rot_t  rout [3]
);
    import e2q_pkg::*;

    rot_t nxt [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nxt[k].neg = rin[k].neg;
            if (!rin[k].z[CW-1])
            begin
                nxt[k].x = rin[k].x - (rin[k].y >>> STEP);
                nxt[k].y = rin[k].y + (rin[k].x >>> STEP);
                nxt[k].z = rin[k].z - atan_q30(STEP);
            end
            else
            begin
                nxt[k].x = rin[k].x + (rin[k].y >>> STEP);
                nxt[k].y = rin[k].y - (rin[k].x >>> STEP);
                nxt[k].z = rin[k].z + atan_q30(STEP);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rout <= nxt;
        end
    end

endmodule

// ===== src/e2q_combine.sv =====
// ============================================================================
// Quaternion combiner
// Rounds sine and cosine, forms triple products from pair products, sums,
// rounds and saturates to Q1.16.
// ============================================================================
module e2q_combine (
    input  logic                                clk,
    input  logic                                en1,
    input  logic                                en2,
    input  logic                                en3,
    input  logic                                en4,
    input  e2q_pkg::rot_t                       rin [3],
    output logic signed [e2q_pkg::OUT_W-1:0]    qx,
    output logic signed [e2q_pkg::OUT_W-1:0]    qy,
    output logic signed [e2q_pkg::OUT_W-1:0]    qz,
    output logic signed [e2q_pkg::OUT_W-1:0]    qw
);
    import e2q_pkg::*;

    logic signed [SC_W-1:0] s_reg [3];
    logic signed [SC_W-1:0] c_reg [3];
    logic signed [SC_W-1:0] s_next [3];
    logic signed [SC_W-1:0] c_next [3];
    // Pairwise products of pitch and yaw terms, kept with roll terms.
    logic signed [43:0] pc_reg, sc_reg, cs_reg, sss_reg;
    logic signed [SC_W-1:0] cr_reg, sr_reg;
    // Each output sum is held as an upper part (weight 2^21) and a lower part.
    logic signed [47:0] hsum_reg [4];
    logic signed [47:0] lsum_reg [4];
    logic signed [47:0] hsum_next [4];
    logic signed [47:0] lsum_next [4];
    logic signed [OUT_W-1:0] q_next [4];

    function automatic logic signed [SC_W-1:0] rnd20(input logic signed [CW-1:0] v,
                                                     input logic neg);
        logic signed [CW:0] t;
        logic signed [CW:0] r;
        begin
            t = neg ? -{v[CW-1], v} : {v[CW-1], v};
            r = (t + 35'sd512) >>> 10;
            if (r > 35'sd1048576)
                return 22'sd1048576;
            else if (r < -35'sd1048576)
                return -22'sd1048576;
            else
                return r[SC_W-1:0];
        end
    endfunction

    // Upper part of a pair term times a roll term: bits 43..21 of the pair.
    function automatic logic signed [47:0] hi_mul(input logic signed [43:0] p,
                                                  input logic signed [SC_W-1:0] r);
        logic signed [22:0] h;
        logic signed [47:0] m;
        begin
            h = p[43:21];
            m = h * r;
            return m;
        end
    endfunction

    // Lower part of a pair term times a roll term: bits 20..0, taken as positive.
    function automatic logic signed [47:0] lo_mul(input logic signed [43:0] p,
                                                  input logic signed [SC_W-1:0] r);
        logic signed [21:0] l;
        logic signed [47:0] m;
        begin
            l = {1'b0, p[20:0]};
            m = l * r;
            return m;
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] fin(input logic signed [66:0] s);
        logic signed [66:0] r;
        begin
            r = (s + (67'sd1 <<< 43)) >>> 44;
            if (r > 67'sd65536)
                return 18'sd65536;
            else if (r < -67'sd65536)
                return -18'sd65536;
            else
                return r[OUT_W-1:0];
        end
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_next[k] = rnd20(rin[k].y, rin[k].neg);
            c_next[k] = rnd20(rin[k].x, rin[k].neg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
        if (en2)
        begin
            sc_reg  <= s_reg[0] * c_reg[1];   // sp*cy
            cs_reg  <= c_reg[0] * s_reg[1];   // cp*sy
            pc_reg  <= c_reg[0] * c_reg[1];   // cp*cy
            sss_reg <= s_reg[0] * s_reg[1];   // sp*sy
            cr_reg  <= c_reg[2];
            sr_reg  <= s_reg[2];
        end
    end

    always_comb
    begin
        hsum_next[0] = hi_mul(sc_reg, cr_reg) + hi_mul(cs_reg, sr_reg);
        lsum_next[0] = lo_mul(sc_reg, cr_reg) + lo_mul(cs_reg, sr_reg);
        hsum_next[1] = hi_mul(cs_reg, cr_reg) - hi_mul(sc_reg, sr_reg);
        lsum_next[1] = lo_mul(cs_reg, cr_reg) - lo_mul(sc_reg, sr_reg);
        hsum_next[2] = hi_mul(pc_reg, sr_reg) - hi_mul(sss_reg, cr_reg);
        lsum_next[2] = lo_mul(pc_reg, sr_reg) - lo_mul(sss_reg, cr_reg);
        hsum_next[3] = hi_mul(pc_reg, cr_reg) + hi_mul(sss_reg, sr_reg);
        lsum_next[3] = lo_mul(pc_reg, cr_reg) + lo_mul(sss_reg, sr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            hsum_reg <= hsum_next;
            lsum_reg <= lsum_next;
        end
    end

    always_comb
    begin
        logic signed [66:0] t;
        for (int k = 0; k < 4; k++)
        begin
            t = hsum_reg[k];
            t = (t <<< 21) + lsum_reg[k];
            q_next[k] = fin(t);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            qx <= q_next[0];
            qy <= q_next[1];
            qz <= q_next[2];
            qw <= q_next[3];
        end
    end

endmodule
